/* hw/rtl/gn2d_pkg.sv */
// ----------------------------------------------------------------------------
// gn2d_pkg
// Shared types and constants for the 2-D gradient noise block.
// ----------------------------------------------------------------------------
package gn2d_pkg;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_EVAL = 1'b1;

    localparam logic signed [31:0] SQRT2_Q30 = 32'sd1518500250;
    localparam logic signed [15:0] ONE_Q14   = 16'sd16384;

    // evaluation context carried beside the four table reads
    typedef struct packed {
        logic        valid;
        logic        zero;
        logic [15:0] tx;
        logic [15:0] ty;
    } eval_ctx_t;

endpackage

/* hw/rtl/gn2d_ram.sv */
// ----------------------------------------------------------------------------
// gn2d_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module gn2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one access per cycle, read data registered
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

/* hw/rtl/gn2d_dot.sv */
// ----------------------------------------------------------------------------
// gn2d_dot
// Corner dot product: offset times gradient, one corner per cycle.
// ----------------------------------------------------------------------------
module gn2d_dot (
    input  logic               clk,
    input  logic signed [17:0] dx,
    input  logic signed [17:0] dy,
    input  logic [31:0]        grad,
    output logic signed [35:0] dot
);

    logic signed [33:0] px_reg;
    logic signed [33:0] py_reg;

    // products registered, then summed
    always_ff @(posedge clk)
    begin
        px_reg <= dx * $signed(grad[15:0]);
        py_reg <= dy * $signed(grad[31:16]);
    end

    assign dot = 36'(px_reg) + 36'(py_reg);

endmodule

/* hw/rtl/gn2d_blend.sv */
// ----------------------------------------------------------------------------
// gn2d_blend
// Smoothstep blend of four dots, sqrt(2) scale and clamp to Q1.14.
// ----------------------------------------------------------------------------
module gn2d_blend (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               zero,
    input  logic [15:0]        tx,
    input  logic [15:0]        ty,
    input  logic signed [35:0] n00,
    input  logic signed [35:0] n10,
    input  logic signed [35:0] n01,
    input  logic signed [35:0] n11,
    output logic               done,
    output logic signed [15:0] result
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_W1   = 7'b0000010,
        S_W2   = 7'b0000100,
        S_ROW  = 7'b0001000,
        S_COL  = 7'b0010000,
        S_SC   = 7'b0100000,
        S_OUT  = 7'b1000000
    } bstate_t;

    bstate_t state_reg, state_next;
    logic signed [35:0] a0_reg, b0_reg, a1_reg, b1_reg;
    logic signed [35:0] r0_reg, r1_reg, v_reg;
    logic [15:0] tx_reg, ty_reg;
    logic [16:0] sx_reg, sy_reg;
    logic [31:0] t2x_reg, t2y_reg;
    logic zero_reg;
    logic signed [67:0] lo_reg, hi_reg;
    logic signed [15:0] res_reg;

    // round shift by 16, half away from zero
    function automatic logic signed [35:0] rnd16(input logic signed [53:0] p);
        logic [53:0] mag;
        logic [53:0] q;
        begin
            mag = p[53] ? 54'(-p) : 54'(p);
            q   = (mag + 54'd32768) >> 16;
            rnd16 = p[53] ? -36'(q) : 36'(q);
        end
    endfunction

    function automatic logic [16:0] smooth(input logic [31:0] t2,
                                           input logic [15:0] t);
        logic [17:0] k;
        logic [49:0] p;
        begin
            k = 18'd196608 - {1'b0, t, 1'b0};
            p = t2 * k;
            smooth = 17'((p + 50'h80000000) >> 32);
        end
    endfunction

    logic signed [53:0] d0, d1, d2;
    logic signed [67:0] full;
    logic [67:0] mag;
    logic [21:0] q;
    logic signed [22:0] r;

    always_comb
    begin
        d0 = (54'(b0_reg) - 54'(a0_reg)) * $signed({1'b0, sx_reg});
        d1 = (54'(b1_reg) - 54'(a1_reg)) * $signed({1'b0, sx_reg});
        d2 = (54'(r1_reg) - 54'(r0_reg)) * $signed({1'b0, sy_reg});
        full = lo_reg + (hi_reg <<< 16);
        mag  = full[67] ? 68'(-full) : 68'(full);
        q    = 22'((mag + (68'd1 << 45)) >> 46);
        r    = full[67] ? -23'(q) : 23'(q);
    end

    // sequencer over weight, row blend, column blend, scale
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (start) state_next = S_W1;
            S_W1:   state_next = S_W2;
            S_W2:   state_next = S_ROW;
            S_ROW:  state_next = S_COL;
            S_COL:  state_next = S_SC;
            S_SC:   state_next = S_OUT;
            S_OUT:  state_next = start ? S_W1 : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a0_reg <= n00; b0_reg <= n10; a1_reg <= n01; b1_reg <= n11;
            tx_reg <= tx; ty_reg <= ty; zero_reg <= zero;
        end
        if (state_reg == S_W1)
        begin
            t2x_reg <= tx_reg * tx_reg;
            t2y_reg <= ty_reg * ty_reg;
        end
        if (state_reg == S_W2)
        begin
            sx_reg <= smooth(t2x_reg, tx_reg);
            sy_reg <= smooth(t2y_reg, ty_reg);
        end
        if (state_reg == S_ROW)
        begin
            r0_reg <= a0_reg + rnd16(d0);
            r1_reg <= a1_reg + rnd16(d1);
        end
        if (state_reg == S_COL)
        begin
            v_reg <= r0_reg + rnd16(d2);
        end
        if (state_reg == S_SC)
        begin
            lo_reg <= 68'(v_reg) * $signed({1'b0, gn2d_pkg::SQRT2_Q30[15:0]});
            hi_reg <= 68'(v_reg) * $signed(gn2d_pkg::SQRT2_Q30[31:16]);
        end
        if (state_reg == S_OUT)
        begin
            if (zero_reg)
                res_reg <= '0;
            else if (r > 23'(gn2d_pkg::ONE_Q14))
                res_reg <= gn2d_pkg::ONE_Q14;
            else if (r < -23'(gn2d_pkg::ONE_Q14))
                res_reg <= -gn2d_pkg::ONE_Q14;
            else
                res_reg <= 16'(r);
        end
    end

    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (state_reg == S_OUT);
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* hw/rtl/gradient_noise_2d.sv */
// ----------------------------------------------------------------------------
// gradient_noise_2d
// 2-D gradient noise over loaded per-layer gradient tables.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid/in_stall) carries load and evaluate
// requests; one output channel (out_valid/out_stall) carries noise_value.
// A load writes one table entry and gives no result; loads
// go through at one per cycle while no evaluation is in flight.
// An evaluate reads its four corner gradients from the single-port table,
// one read per cycle, then forms the dot products, runs the blend/scale
// sequencer and passes the result into the output register; a layer out
// of range skips the table reads and the dot products.
// The input stalls from an evaluate until its result is parked, so
// evaluations do not overlap in the block.
// While the receiver stalls, one result waits in the output register, the
// next finished result waits in the hold register, and input stalls.
// Reset clears control only; table entries are undefined until loaded.
// ----------------------------------------------------------------------------
module gradient_noise_2d #(
    parameter int GRID   = 256,
    parameter int LAYERS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic [1:0]         layer,
    input  logic [15:0]        grid_index,
    input  logic signed [15:0] grad_x,
    input  logic signed [15:0] grad_y,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] noise_value
);

    localparam int CW    = $clog2(GRID);
    localparam int LW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int DEPTH = LAYERS * GRID * GRID;
    localparam int AW    = $clog2(DEPTH);

    // request side: address sequencer
    logic        busy_reg;
    logic [1:0]  cnt_reg;
    logic [LW-1:0] lay_reg;
    logic [CW-1:0] cx0_reg, cx1_reg, cy0_reg, cy1_reg;
    gn2d_pkg::eval_ctx_t ctx_reg;
    logic        blk_busy_reg;
    logic        blk_start;
    logic        done;
    logic signed [15:0] result;
    logic        out_valid_reg;
    logic signed [15:0] out_reg;
    logic        hold_reg;

    logic in_acc;
    assign in_acc   = in_valid && !in_stall;
    assign in_stall = busy_reg || ctx_reg.valid || blk_busy_reg;

    // wrap: cell modulo GRID for any signed integer part
    function automatic logic [CW-1:0] wrap(input logic signed [16:0] c);
        logic signed [16:0] m;
        begin
            m = c % 17'(GRID);
            if (m < 0) m = m + 17'(GRID);
            wrap = CW'(m);
        end
    endfunction

    logic signed [16:0] ix, iy;
    assign ix = 17'($signed(pos_x[31:16]));
    assign iy = 17'($signed(pos_y[31:16]));

    logic lay_ok;
    assign lay_ok = (32'(layer) < 32'(LAYERS));

    // memory port select
    logic          we;
    logic [AW-1:0] addr;
    logic [31:0]   rdata;
    logic [CW-1:0] ax, ay;

    always_comb
    begin
        we   = 1'b0;
        addr = '0;
        ax   = '0;
        ay   = '0;
        if (in_acc && kind == gn2d_pkg::KIND_LOAD)
        begin
            we   = lay_ok && (32'(grid_index) < 32'(GRID * GRID));
            addr = AW'(32'(layer) * GRID * GRID + 32'(grid_index));
        end
        else if (busy_reg)
        begin
            unique case (cnt_reg)
                2'd0: begin ax = cx0_reg; ay = cy0_reg; end
                2'd1: begin ax = cx1_reg; ay = cy0_reg; end
                2'd2: begin ax = cx0_reg; ay = cy1_reg; end
                default: begin ax = cx1_reg; ay = cy1_reg; end
            endcase
            addr = AW'(32'(lay_reg) * GRID * GRID + 32'(ay) * GRID + 32'(ax));
        end
    end

    gn2d_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata ({grad_y, grad_x}),
        .rdata (rdata)
    );

    // read tag pipeline: which corner arrives this cycle
    logic       rd_v_reg;
    logic [1:0] rd_c_reg;
    logic signed [17:0] dx, dy;
    logic       dt_v_reg;
    logic [1:0] dt_c_reg;
    logic signed [35:0] dot;
    logic signed [35:0] n_reg [4];
    logic       fill_reg;

    always_comb
    begin
        dx = rd_c_reg[0] ? 18'($signed({1'b0, ctx_reg.tx})) - 18'sd65536
                         : 18'($signed({1'b0, ctx_reg.tx}));
        dy = rd_c_reg[1] ? 18'($signed({1'b0, ctx_reg.ty})) - 18'sd65536
                         : 18'($signed({1'b0, ctx_reg.ty}));
    end

    gn2d_dot u_dot (
        .clk  (clk),
        .dx   (dx),
        .dy   (dy),
        .grad (rdata),
        .dot  (dot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            ctx_reg  <= '0;
            rd_v_reg <= 1'b0;
            dt_v_reg <= 1'b0;
            fill_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= busy_reg;
            dt_v_reg <= rd_v_reg;
            fill_reg <= dt_v_reg && dt_c_reg == 2'd3;
            if (in_acc && kind == gn2d_pkg::KIND_EVAL)
            begin
                ctx_reg.valid <= 1'b1;
                ctx_reg.zero  <= !lay_ok;
                ctx_reg.tx    <= pos_x[15:0];
                ctx_reg.ty    <= pos_y[15:0];
                busy_reg      <= lay_ok;
                cnt_reg       <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                    busy_reg <= 1'b0;
            end
            if (blk_start)
                ctx_reg.valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_c_reg <= cnt_reg;
        dt_c_reg <= rd_c_reg;
        if (in_acc)
        begin
            lay_reg <= LW'(layer);
            cx0_reg <= wrap(ix);
            cx1_reg <= wrap(ix + 17'sd1);
            cy0_reg <= wrap(iy);
            cy1_reg <= wrap(iy + 17'sd1);
        end
        if (dt_v_reg)
            n_reg[dt_c_reg] <= dot;
    end

    // hand over to blend unit when dots are complete (or layer invalid)
    assign blk_start = ctx_reg.valid && !blk_busy_reg && !busy_reg && !rd_v_reg
                       && !dt_v_reg && (fill_reg || ctx_reg.zero);

    // blend unit stays busy until its result is parked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            blk_busy_reg <= 1'b0;
        else if (blk_start)
            blk_busy_reg <= 1'b1;
        else if ((done || hold_reg) && !(out_valid_reg && out_stall))
            blk_busy_reg <= 1'b0;
    end

    gn2d_blend u_blend (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (blk_start),
        .zero   (ctx_reg.zero),
        .tx     (ctx_reg.tx),
        .ty     (ctx_reg.ty),
        .n00    (n_reg[0]),
        .n10    (n_reg[1]),
        .n01    (n_reg[2]),
        .n11    (n_reg[3]),
        .done   (done),
        .result (result)
    );

    // hold a finished result until the output register frees
    logic signed [15:0] hold_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            hold_reg      <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (hold_reg && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
                hold_reg      <= 1'b0;
            end
            else if (done)
            begin
                if (!out_valid_reg || !out_stall)
                    out_valid_reg <= 1'b1;
                else
                    hold_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_reg && (!out_valid_reg || !out_stall))
            out_reg <= hold_val_reg;
        else if (done && (!out_valid_reg || !out_stall))
            out_reg <= result;
        if (done)
            hold_val_reg <= result;
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = out_reg;

    // result magnitude stays within one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (noise_value <= gn2d_pkg::ONE_Q14 &&
                       noise_value >= -gn2d_pkg::ONE_Q14))
        else $error("noise out of range");

    // no table write while corners are being read
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !we)
        else $error("write during corner read");

    // a result never lands while one is held back
    assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg |-> !(done && !blk_busy_reg))
        else $error("result overflow");

endmodule

/* bench/tb_gradient_noise_2d.sv */
// ----------------------------------------------------------------------------
// tb_gradient_noise_2d
// Drives load and evaluate requests into the gradient noise block with random
// gaps and output stalls, predicts each noise value from a local copy of the
// gradient tables, and compares results in order.
// ----------------------------------------------------------------------------
module tb_gradient_noise_2d;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID     = 256;
    localparam int LAYERS   = 4;
    localparam int N_RANDOM = 1080;
    localparam int IDLE_MAX = 20000;

    // noise value store and mismatch tracking
    class noise_scoreboard;
        logic signed [15:0] pending[$];
        int errors;
        int shown;

        function void note_request(logic signed [15:0] v);
            pending.push_back(v);
        endfunction

        function void check_result(logic signed [15:0] got);
            logic signed [15:0] want;
            if (pending.size() == 0)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("unexpected noise_value %0d", got);
                end
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (shown < 10)
                begin
                    shown++;
                    $display("noise_value mismatch: expected %0d actual %0d", want, got);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               kind;
    logic [1:0]         layer;
    logic [15:0]        grid_index;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] noise_value;

    gradient_noise_2d #(.GRID(GRID), .LAYERS(LAYERS)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .layer(layer), .grid_index(grid_index),
        .grad_x(grad_x), .grad_y(grad_y), .pos_x(pos_x), .pos_y(pos_y),
        .out_valid(out_valid), .out_stall(out_stall), .noise_value(noise_value)
    );

    noise_scoreboard sb = new();

    // local gradient tables, x in low half, y in high half
    logic [31:0] grads [LAYERS*GRID*GRID];
    bit          written [LAYERS*GRID*GRID];
    int          idle_cycles = 0;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int short_or_long_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint round_shift(longint v, int n);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 <<< (n - 1))) >>> n;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic longint smooth(longint t);
        return (t * t * (196608 - 2 * t) + (64'sd1 <<< 31)) >>> 32;
    endfunction

    function automatic longint lerp_q30(longint a, longint b, longint s);
        return a + round_shift((b - a) * s, 16);
    endfunction

    function automatic longint corner_term(int lyr, int cx, int cy, longint dx, longint dy);
        int idx;
        logic signed [15:0] gx, gy;
        idx = lyr * GRID * GRID + (cy & (GRID - 1)) * GRID + (cx & (GRID - 1));
        gx = grads[idx][15:0];
        gy = grads[idx][31:16];
        return dx * longint'(gx) + dy * longint'(gy);
    endfunction

    function automatic logic signed [15:0] predict_noise(int lyr, logic [31:0] px,
                                                        logic [31:0] py);
        int x0, y0;
        longint tx, ty, sx, sy, n00, n10, n01, n11, v, r;
        if (lyr >= LAYERS) return 16'sd0;
        x0 = int'($signed(px[31:16]));
        y0 = int'($signed(py[31:16]));
        tx = px[15:0];
        ty = py[15:0];
        sx = smooth(tx);
        sy = smooth(ty);
        n00 = corner_term(lyr, x0, y0, tx, ty);
        n10 = corner_term(lyr, x0 + 1, y0, tx - 65536, ty);
        n01 = corner_term(lyr, x0, y0 + 1, tx, ty - 65536);
        n11 = corner_term(lyr, x0 + 1, y0 + 1, tx - 65536, ty - 65536);
        v = lerp_q30(lerp_q30(n00, n10, sx), lerp_q30(n01, n11, sx), sy);
        r = round_shift(v * 64'sd1518500250, 46);
        if (r > 16384) r = 16384;
        if (r < -16384) r = -16384;
        return r[15:0];
    endfunction

    // all four corners of the cell under (px,py) loaded in that layer
    function automatic bit corners_loaded(int lyr, logic [31:0] px, logic [31:0] py);
        int x0, y0, base;
        x0 = int'($signed(px[31:16]));
        y0 = int'($signed(py[31:16]));
        base = lyr * GRID * GRID;
        return written[base + (y0 & 255) * GRID + (x0 & 255)]
            && written[base + (y0 & 255) * GRID + ((x0 + 1) & 255)]
            && written[base + ((y0 + 1) & 255) * GRID + (x0 & 255)]
            && written[base + ((y0 + 1) & 255) * GRID + ((x0 + 1) & 255)];
    endfunction

    // one request, held until accepted, then an optional gap
    task automatic send_request(logic k, logic [1:0] lyr, logic [15:0] gi,
                                logic [15:0] gx, logic [15:0] gy,
                                logic [31:0] px, logic [31:0] py);
        int gap;
        in_valid   <= 1'b1;
        kind       <= k;
        layer      <= lyr;
        grid_index <= gi;
        grad_x     <= gx;
        grad_y     <= gy;
        pos_x      <= px;
        pos_y      <= py;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // accepted at this edge
        if (k == gn2d_pkg::KIND_LOAD)
        begin
            if (gi < GRID * GRID && lyr < LAYERS)
            begin
                grads[lyr * GRID * GRID + gi]   = {gy, gx};
                written[lyr * GRID * GRID + gi] = 1'b1;
            end
        end
        else
            sb.note_request(predict_noise(lyr, px, py));
        gap = short_or_long_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_grad(int lyr, int gi, logic [15:0] gx, logic [15:0] gy);
        send_request(gn2d_pkg::KIND_LOAD, lyr[1:0], gi[15:0], gx, gy, $urandom, $urandom);
    endtask

    task automatic eval_at(int lyr, logic [31:0] px, logic [31:0] py);
        send_request(gn2d_pkg::KIND_EVAL, lyr[1:0], 16'($urandom), 16'($urandom),
                     16'($urandom), px, py);
    endtask

    function automatic logic [15:0] rand_grad();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom);
        if (r == 1) return 16'sd16384;
        if (r == 2) return -16'sd16384;
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    // random point in a cell whose corners are loaded (small region per layer)
    function automatic logic [31:0] rand_coord(int cell_lo);
        logic [15:0] ip;
        logic [15:0] fp;
        int r;
        ip = 16'(cell_lo + $urandom_range(0, 2) + 256 * ($urandom_range(0, 3) - 2));
        if ($urandom_range(0, 15) == 0) ip = {8'($urandom_range(0, 255)), ip[7:0]};
        r = $urandom_range(0, 9);
        fp = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'h8000
                                                                 : 16'($urandom);
        return {ip, fp};
    endfunction

    // output side: random stall runs, check on accept
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall) sb.check_result(noise_value);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = short_or_long_gap();
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int lyr, gi, n, k, wait_cycles;
        logic [31:0] px, py;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = gn2d_pkg::KIND_LOAD;
        layer       = '0;
        grid_index  = '0;
        grad_x      = '0;
        grad_y      = '0;
        pos_x       = '0;
        pos_y       = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fill rows 0..3 and 252..255 of cols 0..3, 252..255 in all layers
        for (lyr = 0; lyr < LAYERS; lyr++)
            for (int r = 0; r < 8; r++)
                for (int c = 0; c < 8; c++)
                begin
                    gi = ((r < 4) ? r : r + 248) * GRID + ((c < 4) ? c : c + 248);
                    load_grad(lyr, gi, rand_grad(), rand_grad());
                end
        // extreme gradients, out-of-range gradients, last slot
        load_grad(0, 0, 16'sd16384, 16'sd16384);
        load_grad(0, 1, -16'sd16384, -16'sd16384);
        load_grad(1, 0, 16'h7FFF, 16'h8000);
        load_grad(1, 1, 16'hFFFF, 16'h7FFF);
        load_grad(2, 65535, 16'h1234, 16'h4321);
        // points: origin, edges, wrap at the top, most negative, fractions
        eval_at(0, 32'h0000_0000, 32'h0000_0000);
        eval_at(0, 32'h0000_8000, 32'h0000_8000);
        eval_at(0, 32'h0000_FFFF, 32'h0000_FFFF);
        eval_at(1, 32'h00FF_4000, 32'h00FF_C000);
        eval_at(1, 32'hFFFF_FFFF, 32'hFFFF_0001);
        eval_at(2, 32'h8000_0000, 32'h8000_0000);
        eval_at(3, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        eval_at(3, 32'hFF01_2345, 32'h0102_ABCD);
        eval_at(0, 32'h0001_0000, 32'hFFFE_FFFF);

        // random mix: mostly evaluations over loaded cells, some reloads
        for (n = 0; n < N_RANDOM; n++)
        begin
            k = $urandom_range(0, 9);
            lyr = $urandom_range(0, 3);
            if (k < 2)
            begin
                if ($urandom_range(0, 7) == 0)
                    gi = (GRID * GRID) + $urandom_range(0, GRID * GRID - 1);
                else
                    gi = $urandom_range(0, GRID * GRID - 1);
                load_grad(lyr, gi, rand_grad(), rand_grad());
            end
            else
            begin
                px = rand_coord(($urandom_range(0, 1) == 0) ? 0 : 253);
                py = rand_coord(($urandom_range(0, 1) == 0) ? 0 : 253);
                if (corners_loaded(lyr, px, py))
                    eval_at(lyr, px, py);
                else
                    eval_at(lyr, {px[31:16] & 16'h0001, px[15:0]}, {16'h0001, py[15:0]});
            end
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending.size() != 0 && wait_cycles < 200000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);
        if (sb.pending.size() == 0 && sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

/* gradient_noise_2d.f */
hw/rtl/gn2d_pkg.sv
hw/rtl/gn2d_ram.sv
hw/rtl/gn2d_dot.sv
hw/rtl/gn2d_blend.sv
hw/rtl/gradient_noise_2d.sv
bench/tb_gradient_noise_2d.sv
